>>> design/rational_arithmetic_unit_defines.svh
// ---------------------------------------------------------------------------
// Rational arithmetic unit: assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RAU_ASSERT_SAME(lbl, ante, cons)
`define RAU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/rau_pkg.sv
// ---------------------------------------------------------------------------
// Rational arithmetic unit package
// Widths, command and status codes shared by the controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package rau_pkg;
  localparam int OPW   = 32;
  localparam int MW    = 2 * OPW;
  localparam int KW    = $clog2(MW + 1);
  localparam int CNT_W = $clog2(MW);
  localparam int CMD_W = 3;

  localparam logic [1:0] REQ_ADD = 2'd0;
  localparam logic [1:0] REQ_SUB = 2'd1;
  localparam logic [1:0] REQ_MUL = 2'd2;
  localparam logic [1:0] REQ_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [CMD_W-1:0] CMD_NONE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GCD  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DIVI = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_OUT  = 3'd7;

  localparam logic [1:0] MSEL_P = 2'd0;
  localparam logic [1:0] MSEL_Q = 2'd1;
  localparam logic [1:0] MSEL_D = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [1:0]       msel;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic gcd_done;
  } stat_t;

  // Sign and magnitude of an OPW-bit two's complement value.
  function automatic logic [OPW:0] to_smag(logic [OPW-1:0] v);
    logic neg;
    neg = v[OPW-1];
    return {neg, neg ? (~v + OPW'(1)) : v};
  endfunction
endpackage

>>> design/rau_dp.sv
// ---------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Shared multiplier, signed adder, binary GCD and two restoring dividers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rau_dp import rau_pkg::*; (
  input  logic               clk,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic [1:0]         out_status
);
  logic [1:0]     op_r;
  logic [OPW-1:0] an_r, ad_r, bn_r, bd_r;
  logic           an_s_r, ad_s_r, bn_s_r, bd_s_r;
  logic           err_r;
  logic [MW-1:0]  p_r, q_r, den_r;
  logic           p_s_r, q_s_r, den_s_r;
  logic [MW-1:0]  u_r, v_r, g_r;
  logic [KW-1:0]  k_r;
  logic           neg_r;
  logic [MW-1:0]  nq_r, dq_r, nrem_r, drem_r;
  logic signed [31:0] res_num_r;
  logic [30:0]    res_den_r;
  logic [1:0]     status_r;

  logic [OPW:0]   an_c, ad_c, bn_c, bd_c;
  logic [OPW-1:0] mul_a, mul_b;
  logic           mul_s;
  logic [MW-1:0]  prod;
  logic           qs;
  logic [MW-1:0]  sum_mag;
  logic           sum_s;
  logic [MW:0]    nt, dt;
  logic [MW-1:0]  lim;
  logic           ovf;
  logic [OPW-1:0] num_val;

  assign an_c = to_smag(in_a_num[OPW-1:0]);
  assign ad_c = to_smag(in_a_den[OPW-1:0]);
  assign bn_c = to_smag(in_b_num[OPW-1:0]);
  assign bd_c = to_smag(in_b_den[OPW-1:0]);

  always_comb begin
    unique case (cmd.msel)
      MSEL_P: begin
        mul_a = an_r;
        mul_b = (op_r == REQ_MUL) ? bn_r : bd_r;
        mul_s = an_s_r ^ ((op_r == REQ_MUL) ? bn_s_r : bd_s_r);
      end
      MSEL_Q: begin
        mul_a = bn_r;
        mul_b = ad_r;
        mul_s = bn_s_r ^ ad_s_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = (op_r == REQ_DIV) ? bn_r : bd_r;
        mul_s = ad_s_r ^ ((op_r == REQ_DIV) ? bn_s_r : bd_s_r);
      end
    endcase
  end
  assign prod = MW'(mul_a) * MW'(mul_b);

  always_comb begin
    qs = q_s_r ^ (op_r == REQ_SUB);
    if (op_r == REQ_MUL || op_r == REQ_DIV) begin
      sum_mag = p_r;
      sum_s   = p_s_r;
    end else if (p_s_r == qs) begin
      sum_mag = p_r + q_r;
      sum_s   = p_s_r;
    end else if (p_r >= q_r) begin
      sum_mag = p_r - q_r;
      sum_s   = p_s_r;
    end else begin
      sum_mag = q_r - p_r;
      sum_s   = qs;
    end
  end

  assign nt  = {nrem_r, nq_r[MW-1]};
  assign dt  = {drem_r, dq_r[MW-1]};
  assign lim = MW'(1) << (OPW - 1);
  assign ovf = (dq_r > lim - MW'(1)) || (neg_r ? (nq_r > lim) : (nq_r > lim - MW'(1)));
  assign num_val = neg_r ? (~nq_r[OPW-1:0] + OPW'(1)) : nq_r[OPW-1:0];

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_LOAD: begin
        op_r   <= in_req_type;
        an_r   <= an_c[OPW-1:0];
        ad_r   <= ad_c[OPW-1:0];
        bn_r   <= bn_c[OPW-1:0];
        bd_r   <= bd_c[OPW-1:0];
        an_s_r <= an_c[OPW];
        ad_s_r <= ad_c[OPW];
        bn_s_r <= bn_c[OPW];
        bd_s_r <= bd_c[OPW];
        err_r  <= (ad_c[OPW-1:0] == '0) || (bd_c[OPW-1:0] == '0) ||
                  ((in_req_type == REQ_DIV) && (bn_c[OPW-1:0] == '0));
      end
      CMD_MUL: begin
        unique case (cmd.msel)
          MSEL_P: begin
            p_r   <= prod;
            p_s_r <= mul_s;
          end
          MSEL_Q: begin
            q_r   <= prod;
            q_s_r <= mul_s;
          end
          default: begin
            den_r   <= prod;
            den_s_r <= mul_s;
          end
        endcase
      end
      CMD_ADD: begin
        p_r   <= sum_mag;
        u_r   <= sum_mag;
        v_r   <= den_r;
        k_r   <= '0;
        neg_r <= (sum_mag != '0) && (sum_s != den_s_r);
      end
      CMD_GCD: begin
        if (!stat.gcd_done) begin
          priority if (!u_r[0] && !v_r[0]) begin
            u_r <= u_r >> 1;
            v_r <= v_r >> 1;
            k_r <= k_r + KW'(1);
          end else if (!u_r[0]) begin
            u_r <= u_r >> 1;
          end else if (!v_r[0]) begin
            v_r <= v_r >> 1;
          end else if (u_r >= v_r) begin
            u_r <= u_r - v_r;
          end else begin
            v_r <= v_r - u_r;
          end
        end
      end
      CMD_DIVI: begin
        g_r    <= ((u_r == '0) ? v_r : u_r) << k_r;
        nq_r   <= p_r;
        dq_r   <= den_r;
        nrem_r <= '0;
        drem_r <= '0;
      end
      CMD_DIV: begin
        if (nt >= {1'b0, g_r}) begin
          nrem_r <= MW'(nt - {1'b0, g_r});
          nq_r   <= {nq_r[MW-2:0], 1'b1};
        end else begin
          nrem_r <= nt[MW-1:0];
          nq_r   <= {nq_r[MW-2:0], 1'b0};
        end
        if (dt >= {1'b0, g_r}) begin
          drem_r <= MW'(dt - {1'b0, g_r});
          dq_r   <= {dq_r[MW-2:0], 1'b1};
        end else begin
          drem_r <= dt[MW-1:0];
          dq_r   <= {dq_r[MW-2:0], 1'b0};
        end
      end
      CMD_OUT: begin
        priority if (err_r) begin
          res_num_r <= '0;
          res_den_r <= '0;
          status_r  <= ST_ZERO;
        end else if (ovf) begin
          res_num_r <= '0;
          res_den_r <= '0;
          status_r  <= ST_OVF;
        end else begin
          res_num_r <= 32'($signed(num_val));
          res_den_r <= 31'(dq_r[OPW-2:0]);
          status_r  <= ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.err      = err_r;
  assign stat.gcd_done = (u_r == '0) || (v_r == '0);
  assign out_res_num   = res_num_r;
  assign out_res_den   = res_den_r;
  assign out_status    = status_r;
endmodule

>>> design/rau_ctrl.sv
// ---------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences load, products, sum, GCD, division and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rau_ctrl import rau_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL0 = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_ADD  = 4'd4;
  localparam logic [3:0] S_GCD  = 4'd5;
  localparam logic [3:0] S_DIVI = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = CMD_NONE;
    cmd.msel      = MSEL_P;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = CMD_LOAD;
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.op    = CMD_MUL;
        state_nxt = stat.err ? S_FIN : S_MUL1;
      end
      S_MUL1: begin
        cmd.op    = CMD_MUL;
        cmd.msel  = MSEL_Q;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op    = CMD_MUL;
        cmd.msel  = MSEL_D;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.op    = CMD_ADD;
        state_nxt = S_GCD;
      end
      S_GCD: begin
        cmd.op = CMD_GCD;
        if (stat.gcd_done) begin
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.op    = CMD_DIVI;
        cnt_nxt   = CNT_W'(MW - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = CMD_DIV;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = CMD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
endmodule

>>> design/rational_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ---------------------------------------------------------------------------
// Usage: an input transaction carries an opcode and two signed fractions on
// the in_ channel (valid/ready). One result transaction, a reduced fraction
// with a status code and a denominator that is positive (0/0 on an error),
// follows on the out_ channel. Only one transaction is in flight: in_ready
// is high while the unit is idle. After acceptance the unit forms the products
// and the new numerator, finds the GCD of the 64-bit numerator and denominator
// magnitudes by binary GCD steps (fewer for small operands) and divides both
// by it. The GCD loop and the 64-step restoring division by the GCD take the
// bulk of the time; the three cross products share one 32 x 32 multiplier,
// one per cycle. A zero denominator or a zero divisor skips to the result.
// Synchronous active-low reset clears the controller and drops out_valid.
// The result sits in an output register, so a stalled receiver holds it
// while the next transaction is accepted; that transaction then waits
// finished until the register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic [1:0]         out_status
);
  // Command and status are the only link between controller and datapath.
  cmd_t  cmd;
  stat_t stat;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rau_dp u_dp (
    .clk         (clk),
    .in_req_type (in_req_type),
    .in_a_num    (in_a_num),
    .in_a_den    (in_a_den),
    .in_b_num    (in_b_num),
    .in_b_den    (in_b_den),
    .cmd         (cmd),
    .stat        (stat),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_status  (out_status)
  );

  // A transaction is accepted only when idle, so the unit is busy afterwards.
  `RAU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // The status code never takes the unused value.
  `RAU_ASSERT_SAME(a_status_legal, out_valid, out_status != 2'd3)
  // A good result always has a non-zero denominator.
  `RAU_ASSERT_SAME(a_den_nonzero, out_valid && (out_status == ST_OK), out_res_den != '0)
endmodule

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction operations through the unit and checks every result
// against a fraction predictor with GCD reduction, under varied idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top import rau_pkg::*; ();

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Input channel.
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_req_type = REQ_ADD;
  logic signed [31:0] in_a_num = '0;
  logic signed [31:0] in_a_den = '0;
  logic signed [31:0] in_b_num = '0;
  logic signed [31:0] in_b_den = '0;

  // Result channel.
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_res_num;
  logic [30:0]        out_res_den;
  logic [1:0]         out_status;

  rational_arithmetic_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_a_num    (in_a_num),
    .in_a_den    (in_a_den),
    .in_b_num    (in_b_num),
    .in_b_den    (in_b_den),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_status  (out_status)
  );

  // One expected reduced fraction with its status.
  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic [1:0]         status;
  } fraction_t;

  // A row of the directed table. When has_fixed is set the expected result
  // is given in the row and also cross-checked by the predictor.
  typedef struct {
    logic [1:0]  op;
    logic [31:0] an, ad, bn, bd;
    bit          has_fixed;
    fraction_t   fixed;
  } vector_t;

  fraction_t expected_fractions[$];
  int        error_count   = 0;
  int        results_seen  = 0;
  int        items_sent    = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // Greatest common divisor of two 64-bit magnitudes, Euclid style.
  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Works out the reduced fraction for one operation. Every product is kept
  // as sign plus a 64-bit magnitude, so nothing can wrap before reduction.
  function automatic fraction_t reduce_fraction(logic [1:0] op, logic [31:0] an,
                                                logic [31:0] ad, logic [31:0] bn,
                                                logic [31:0] bd);
    fraction_t   r;
    logic        san, sad, sbn, sbd, sp, sq, snum, sden, neg;
    logic [63:0] man, mad, mbn, mbd, mp, mq, mnum, mden, g;
    san = an[31]; sad = ad[31]; sbn = bn[31]; sbd = bd[31];
    man = san ? 64'(-$signed(64'($signed(an)))) : 64'(an);
    mad = sad ? 64'(-$signed(64'($signed(ad)))) : 64'(ad);
    mbn = sbn ? 64'(-$signed(64'($signed(bn)))) : 64'(bn);
    mbd = sbd ? 64'(-$signed(64'($signed(bd)))) : 64'(bd);
    r.num = '0;
    r.den = '0;
    r.status = ST_OK;
    if (mad == 0 || mbd == 0 || (op == REQ_DIV && mbn == 0)) begin
      r.status = ST_ZERO;
      return r;
    end
    case (op)
      REQ_ADD, REQ_SUB: begin
        sp = san ^ sbd; mp = man * mbd;
        sq = sbn ^ sad; mq = mbn * mad;
        if (op == REQ_SUB) sq = ~sq;
        if (sp == sq) begin
          snum = sp; mnum = mp + mq;
        end else if (mp >= mq) begin
          snum = sp; mnum = mp - mq;
        end else begin
          snum = sq; mnum = mq - mp;
        end
        sden = sad ^ sbd; mden = mad * mbd;
      end
      REQ_MUL: begin
        snum = san ^ sbn; mnum = man * mbn;
        sden = sad ^ sbd; mden = mad * mbd;
      end
      default: begin
        snum = san ^ sbd; mnum = man * mbd;
        sden = sad ^ sbn; mden = mad * mbn;
      end
    endcase
    neg = (mnum != 0) && (snum != sden);
    g = gcd64(mnum, mden);
    mnum = mnum / g;
    mden = mden / g;
    if (mden > 64'h7FFF_FFFF || (neg ? mnum > 64'h8000_0000 : mnum > 64'h7FFF_FFFF)) begin
      r.status = ST_OVF;
      return r;
    end
    r.num = neg ? 32'(-mnum) : mnum[31:0];
    r.den = mden[30:0];
    return r;
  endfunction

  // Random operand with a bias towards small values and the extremes, so
  // that reductions, zero results and overflows all turn up.
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'($signed($urandom_range(8)) - 4);
      3, 4:    return 32'($signed($urandom_range(2000)) - 1000);
      5:       return 32'($signed($urandom_range(131072)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  // Sends one transaction, holding valid and payload until it is accepted.
  // The idle decision is made per cycle, so gaps land on every state of the
  // unit. valid stays high between back-to-back transactions.
  task automatic send_item(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= op;
    in_a_num    <= an;
    in_a_den    <= ad;
    in_b_num    <= bn;
    in_b_den    <= bd;
    expected_fractions.push_back(reduce_fraction(op, an, ad, bn, bd));
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: out_ready is chosen afresh every cycle from the stall rate.
  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Scoreboard: a result counts when valid and ready are both high at a
  // rising edge; it is compared with the oldest outstanding expectation.
  always @(posedge clk) begin
    fraction_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_fractions.size() == 0) begin
        $error("result transaction with nothing expected: %0d/%0d status %0d",
               out_res_num, out_res_den, out_status);
        error_count++;
      end else begin
        e = expected_fractions.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_status);
          error_count++;
        end
        if (out_res_num !== e.num) begin
          $error("res_num: expected %0d, actual %0d", e.num, out_res_num);
          error_count++;
        end
        if (out_res_den !== e.den) begin
          $error("res_den: expected %0d, actual %0d", e.den, out_res_den);
          error_count++;
        end
      end
    end
  end

  // Directed table: extremes, every operation and the special cases.
  vector_t directed[$];

  task automatic add_row(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                         logic [31:0] bn, logic [31:0] bd, int fixed,
                         logic signed [31:0] rn, logic [31:0] rd, logic [1:0] st);
    vector_t v;
    v.op = op; v.an = an; v.ad = ad; v.bn = bn; v.bd = bd;
    v.has_fixed = (fixed != 0);
    v.fixed.num = rn; v.fixed.den = rd[30:0]; v.fixed.status = st;
    directed.push_back(v);
  endtask

  task automatic build_table();
    // Zero operand denominators, for each operation, give the error code.
    add_row(REQ_ADD, 1, 0, 1, 1, 1, 0, 0, ST_ZERO);
    add_row(REQ_SUB, 1, 1, 1, 0, 1, 0, 0, ST_ZERO);
    add_row(REQ_MUL, 5, 0, 7, 0, 1, 0, 0, ST_ZERO);
    add_row(REQ_DIV, 5, 0, 7, 3, 1, 0, 0, ST_ZERO);
    // Divide by a zero numerator.
    add_row(REQ_DIV, 3, 4, 0, 9, 1, 0, 0, ST_ZERO);
    // A zero result comes back as 0/1.
    add_row(REQ_SUB, 3, 4, 3, 4, 1, 0, 1, ST_OK);
    add_row(REQ_MUL, 0, -7, 5, 3, 1, 0, 1, ST_OK);
    // Negative denominators move their sign to the numerator.
    add_row(REQ_MUL, 1, -2, 1, 1, 1, -1, 2, ST_OK);
    add_row(REQ_ADD, -1, -2, -1, -2, 1, 1, 1, ST_OK);
    // Plain cases of each operation.
    add_row(REQ_ADD, 1, 2, 1, 3, 1, 5, 6, ST_OK);
    add_row(REQ_SUB, 1, 2, 1, 3, 1, 1, 6, ST_OK);
    add_row(REQ_MUL, 2, 3, 9, 4, 1, 3, 2, ST_OK);
    add_row(REQ_DIV, 2, 3, 4, 9, 1, 3, 2, ST_OK);
    // Extremes of the operand range.
    add_row(REQ_MUL, 32'h8000_0000, 1, 1, 1, 1, 32'h8000_0000, 1, ST_OK);
    add_row(REQ_MUL, 32'h8000_0000, -1, 1, 1, 1, 0, 0, ST_OVF);
    add_row(REQ_MUL, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1, 1, 0, 0, ST_OVF);
    add_row(REQ_MUL, 1, 32'h8000_0000, 1, 1, 1, 0, 0, ST_OVF);
    add_row(REQ_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            1, 1, 1, ST_OK);
    add_row(REQ_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1, 1, 0, 0, ST_OVF);
    add_row(REQ_SUB, 32'h8000_0000, 1, 1, 1, 1, 0, 0, ST_OVF);
    // Rows left to the predictor.
    add_row(REQ_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
            0, 0, 0, ST_OK);
    add_row(REQ_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            0, 0, 0, ST_OK);
    add_row(REQ_SUB, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
            0, 0, 0, ST_OK);
  endtask

  task automatic wait_drained();
    while (expected_fractions.size() != 0) @(posedge clk);
  endtask

  // Random phase: mostly well-formed operands, with a share of zero
  // denominators and zero divisors mixed in as error noise.
  task automatic random_phase(int count, int idle_pct, int stall_pct);
    logic [31:0] an, ad, bn, bd;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      an = rand_operand(); ad = rand_operand();
      bn = rand_operand(); bd = rand_operand();
      if ($urandom_range(19) == 0) ad = 0;
      if ($urandom_range(19) == 0) bd = 0;
      if ($urandom_range(19) == 0) bn = 0;
      send_item(2'($urandom_range(3)), an, ad, bn, bd);
    end
  endtask

  // Main sequence.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    build_table();
    foreach (directed[i]) begin
      send_item(directed[i].op, directed[i].an, directed[i].ad,
                directed[i].bn, directed[i].bd);
      if (directed[i].has_fixed &&
          expected_fractions[$] != directed[i].fixed) begin
        $error("predictor row %0d: expected %0d/%0d status %0d, predicted %0d/%0d status %0d",
               i, directed[i].fixed.num, directed[i].fixed.den, directed[i].fixed.status,
               expected_fractions[$].num, expected_fractions[$].den,
               expected_fractions[$].status);
        error_count++;
      end
    end
    // Hold the sender back until every outstanding result is in.
    drop_valid();
    wait_drained();
    random_phase(500, 0, 0);
    random_phase(480, 63, 0);
    drop_valid();
    wait_drained();
    random_phase(480, 0, 63);
    random_phase(470, 30, 30);
    drop_valid();
    wait_drained();
    repeat (300) @(posedge clk);
    $display("Sent %0d fraction transactions over all four operations, ", items_sent);
    $display("%0d results checked, under four idling phases.", results_seen);
    if (error_count == 0 && expected_fractions.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: well over the slowest run of about 2000 transactions,
  // stretched by idling and stalls.
  initial begin
    #50ms;
    $display("tb_top failed");
    $finish;
  end
endmodule

>>> rational_arithmetic_unit.f
+incdir+design
design/rau_pkg.sv
design/rau_dp.sv
design/rau_ctrl.sv
design/rational_arithmetic_unit.sv
tb/tb_top.sv
